// File: hw/rtl/pcg32_pkg.sv
package pcg32_pkg;

    localparam logic [63:0] PCG_MULT = 64'd6364136223846793005;
    localparam int XS_SHIFT_A = 18;
    localparam int XS_SHIFT_B = 27;
    localparam int ROT_LSB    = 59;
    localparam int FRAC24_SHIFT = 8;
    localparam int FRAC53_SHIFT = 11;
    localparam int DIV_STEPS  = 32;

    localparam logic CFG_SEED   = 1'b0;
    localparam logic CFG_STREAM = 1'b1;

    typedef enum logic [2:0] {
        REQ_RESEED  = 3'd0,
        REQ_U32     = 3'd1,
        REQ_U64     = 3'd2,
        REQ_BOUNDED = 3'd3,
        REQ_FRAC24  = 3'd4,
        REQ_FRAC53  = 3'd5
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RS_INIT,
        ST_WORD,
        ST_POST,
        ST_DIV,
        ST_DIV_END,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic       take;
        logic       reseed_init;
        logic       add_seed;
        logic       mul_go;
        logic [1:0] mul_phase;
        logic       clear_result;
        logic       load_word;
        logic       shift_in;
        logic       frac24;
        logic       frac53;
        logic       div_load_thr;
        logic       div_load_word;
        logic       div_step;
        logic       result_rem;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic bound_zero;
        logic word_lt_thr;
    } dp_status_t;

endpackage

// File: hw/rtl/pcg32_random_generator_top.sv
// PCG32 XSH-RR random generator.
// Request channel: req_valid / req_stall with req_type and bound. An item is
// taken at a clock edge where req_valid is high and req_stall is low; the
// block raises req_stall while it works on an item.
// Response channel: rsp_valid / rsp_stall with value, one item per request.
// Configuration: cfg_we writes seed (index 0) or stream (index 1) from
// cfg_data; write only while idle. Reseed applies them.
// Each 32-bit word goes through one shared 32x32 multiplier (three partial
// products, then the state update). u32 and Q0.24 requests use one word,
// u64 and Q0.53 requests two; reseed runs two state updates. A bounded
// draw runs the 32-step remainder unit for the threshold, draws words,
// discarding each one below the threshold, then runs the remainder unit
// again on the accepted word. Bound zero and undefined request types
// answer zero without drawing a word. A new request is taken only once
// the previous result has reached the output register.
// A finished result moves into the output register, so the next request
// is taken while the previous response still waits on rsp_stall; if the
// output register is still full, the block holds its result until it drains.
// Reset: state 0, increment 1, seed and stream 0, no response pending.
module pcg32_random_generator_top
    import pcg32_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [2:0]  req_type,
    input  logic [31:0] bound,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [63:0] value
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequence each request: word generation, reseed steps, rejection loop
    pcg32_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req_type),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // hold generator state, multiplier, remainder unit and result registers
    pcg32_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bound     (bound),
        .cmd       (cmd),
        .status    (status),
        .value     (value)
    );

endmodule

// File: hw/rtl/pcg32_dpath.sv
module pcg32_dpath
    import pcg32_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic [31:0] bound,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output logic [63:0] value
);

    logic [63:0] state_reg, state_next;
    logic [63:0] inc_reg, inc_next;
    logic [63:0] seed_reg, seed_next;
    logic [62:0] stream_reg, stream_next;
    logic [31:0] bound_reg, bound_next;
    logic [63:0] mp_reg, mp_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] word_reg, word_next;
    logic [63:0] result_reg, result_next;
    logic [31:0] dd_reg, dd_next;
    logic [31:0] rem_reg, rem_next;
    logic [63:0] value_reg, value_next;

    logic [31:0] mul_a, mul_b;
    logic [32:0] trial;
    logic [32:0] trial_sub;

    // XSH-RR output permutation of the old state
    function automatic logic [31:0] permute(input logic [63:0] old);
        logic [63:0] xs;
        logic [4:0]  rot;
        logic [63:0] dbl;
        xs  = ((old >> XS_SHIFT_A) ^ old) >> XS_SHIFT_B;
        rot = old[63:ROT_LSB];
        dbl = {xs[31:0], xs[31:0]} >> rot;
        return dbl[31:0];
    endfunction

    always_comb
    begin
        case (cmd.mul_phase)
            2'd1:
            begin
                mul_a = state_reg[63:32];
                mul_b = PCG_MULT[31:0];
            end
            2'd2:
            begin
                mul_a = state_reg[31:0];
                mul_b = PCG_MULT[63:32];
            end
            default:
            begin
                mul_a = state_reg[31:0];
                mul_b = PCG_MULT[31:0];
            end
        endcase
    end

    assign trial     = {rem_reg, dd_reg[31]};
    assign trial_sub = trial - {1'b0, bound_reg};

    always_comb
    begin
        state_next  = state_reg;
        inc_next    = inc_reg;
        seed_next   = seed_reg;
        stream_next = stream_reg;
        bound_next  = bound_reg;
        mp_next     = mp_reg;
        acc_next    = acc_reg;
        word_next   = word_reg;
        result_next = result_reg;
        dd_next     = dd_reg;
        rem_next    = rem_reg;
        value_next  = value_reg;

        if (cfg_we)
        begin
            if (cfg_index == CFG_SEED)
                seed_next = cfg_data;
            else
                stream_next = cfg_data[62:0];
        end

        if (cmd.take)
            bound_next = bound;

        if (cmd.reseed_init)
        begin
            state_next = '0;
            inc_next   = {stream_reg, 1'b1};
        end

        if (cmd.add_seed)
            state_next = state_reg + seed_reg;

        // low 64 bits of state * PCG_MULT from three 32x32 partial products
        if (cmd.mul_go)
        begin
            mp_next = mul_a * mul_b;
            case (cmd.mul_phase)
                2'd1: acc_next = mp_reg;
                2'd2: acc_next = acc_reg + {mp_reg[31:0], 32'd0};
                2'd3:
                begin
                    state_next = acc_reg + {mp_reg[31:0], 32'd0} + inc_reg;
                    word_next  = permute(state_reg);
                end
                default: acc_next = acc_reg;
            endcase
        end

        if (cmd.clear_result)
            result_next = '0;
        if (cmd.load_word)
            result_next = {32'd0, word_reg};
        if (cmd.shift_in)
            result_next = {result_reg[31:0], word_reg};
        if (cmd.frac24)
            result_next = {40'd0, word_reg[31:FRAC24_SHIFT]};
        if (cmd.frac53)
            result_next = {result_reg[31:0], word_reg} >> FRAC53_SHIFT;

        if (cmd.div_load_thr)
        begin
            dd_next  = 32'd0 - bound;
            rem_next = '0;
        end
        if (cmd.div_load_word)
        begin
            dd_next  = word_reg;
            rem_next = '0;
        end
        if (cmd.div_step)
        begin
            dd_next  = {dd_reg[30:0], 1'b0};
            rem_next = trial_sub[32] ? trial[31:0] : trial_sub[31:0];
        end
        if (cmd.result_rem)
            result_next = {32'd0, rem_reg};

        if (cmd.out_load)
            value_next = result_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= '0;
            inc_reg    <= 64'd1;
            seed_reg   <= '0;
            stream_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            inc_reg    <= inc_next;
            seed_reg   <= seed_next;
            stream_reg <= stream_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bound_reg  <= bound_next;
        mp_reg     <= mp_next;
        acc_reg    <= acc_next;
        word_reg   <= word_next;
        result_reg <= result_next;
        dd_reg     <= dd_next;
        rem_reg    <= rem_next;
        value_reg  <= value_next;
    end

    assign status.bound_zero  = (bound == 32'd0);
    assign status.word_lt_thr = (word_reg < rem_reg);
    assign value = value_reg;

endmodule

// File: hw/rtl/pcg32_ctrl.sv
module pcg32_ctrl
    import pcg32_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [2:0] req_type,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t st_reg, st_next;
    req_t        req_reg, req_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        second_reg, second_next;
    logic        final_reg, final_next;
    logic        rsp_valid_reg, rsp_valid_next;
    logic        slot_free;

    assign slot_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            req_reg       <= REQ_RESEED;
            cnt_reg       <= '0;
            second_reg    <= 1'b0;
            final_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            req_reg       <= req_next;
            cnt_reg       <= cnt_next;
            second_reg    <= second_next;
            final_reg     <= final_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        st_next     = st_reg;
        req_next    = req_reg;
        cnt_next    = cnt_reg;
        second_next = second_reg;
        final_next  = final_reg;
        cmd         = '0;
        cmd.mul_phase = cnt_reg[1:0];

        rsp_valid_next = (rsp_valid_reg && rsp_stall) ? 1'b1 : 1'b0;

        case (st_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.take    = 1'b1;
                    req_next    = req_t'(req_type);
                    cnt_next    = '0;
                    second_next = 1'b0;
                    final_next  = 1'b0;
                    case (req_type)
                        REQ_RESEED:
                            st_next = ST_RS_INIT;
                        REQ_U32, REQ_U64, REQ_FRAC24, REQ_FRAC53:
                            st_next = ST_WORD;
                        REQ_BOUNDED:
                        begin
                            if (status.bound_zero)
                            begin
                                cmd.clear_result = 1'b1;
                                st_next = ST_DONE;
                            end
                            else
                            begin
                                cmd.div_load_thr = 1'b1;
                                st_next = ST_DIV;
                            end
                        end
                        default:
                        begin
                            cmd.clear_result = 1'b1;
                            st_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RS_INIT:
            begin
                cmd.reseed_init = 1'b1;
                cnt_next = '0;
                st_next  = ST_WORD;
            end
            ST_WORD:
            begin
                cmd.mul_go = 1'b1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    cnt_next = '0;
                    st_next  = ST_POST;
                end
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            ST_POST:
            begin
                cnt_next = '0;
                case (req_reg)
                    REQ_RESEED:
                    begin
                        if (!second_reg)
                        begin
                            cmd.add_seed = 1'b1;
                            second_next  = 1'b1;
                            st_next      = ST_WORD;
                        end
                        else
                        begin
                            cmd.clear_result = 1'b1;
                            st_next = ST_DONE;
                        end
                    end
                    REQ_U32:
                    begin
                        cmd.load_word = 1'b1;
                        st_next = ST_DONE;
                    end
                    REQ_U64:
                    begin
                        cmd.shift_in = 1'b1;
                        second_next  = 1'b1;
                        st_next = second_reg ? ST_DONE : ST_WORD;
                    end
                    REQ_FRAC24:
                    begin
                        cmd.frac24 = 1'b1;
                        st_next = ST_DONE;
                    end
                    REQ_FRAC53:
                    begin
                        second_next = 1'b1;
                        if (second_reg)
                        begin
                            cmd.frac53 = 1'b1;
                            st_next = ST_DONE;
                        end
                        else
                        begin
                            cmd.shift_in = 1'b1;
                            st_next = ST_WORD;
                        end
                    end
                    REQ_BOUNDED:
                    begin
                        if (status.word_lt_thr)
                            st_next = ST_WORD;
                        else
                        begin
                            cmd.div_load_word = 1'b1;
                            final_next = 1'b1;
                            st_next = ST_DIV;
                        end
                    end
                    default:
                    begin
                        cmd.clear_result = 1'b1;
                        st_next = ST_DONE;
                    end
                endcase
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                    st_next = ST_DIV_END;
            end
            ST_DIV_END:
            begin
                cnt_next = '0;
                if (final_reg)
                begin
                    cmd.result_rem = 1'b1;
                    st_next = ST_DONE;
                end
                else
                    st_next = ST_WORD;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    st_next        = ST_IDLE;
                end
            end
            default:
                st_next = ST_IDLE;
        endcase
    end

    assign req_stall = (st_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule
